>>> rtl/rtnh_pkg.sv
// Shared constants, codes and types of the ray and triangle nearest-hit engine.
package rtnh_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int DIST_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    // Wide enough to count the longest multiplier operand at 48-bit coordinates.
    localparam int CNT_W       = 7;
    // Width of the signed cosine-bound constants.
    localparam int KW          = 15;

    localparam logic [KW-1:0] COS_SQ_DEN = 15'd10000;
    localparam logic [KW-1:0] COS_SQ_NUM = 15'd9801;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORG_X,
        REG_ORG_Y,
        REG_ORG_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ACC_ZERO,
        ACC_KEEP,
        ACC_LOAD
    } t_acc_mode;

    typedef struct packed {
        logic             start;
        t_acc_mode        mode;
        logic             sub;
        logic [CNT_W-1:0] nbits;
    } t_mac_ctl;

endpackage

>>> rtl/rtnh_if.sv
// Handshake channels for triangle words in and result words out.
interface rtnh_tri_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
    logic                          final_tri;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_tri,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_tri,
        output ready
    );
endinterface

interface rtnh_res_if import rtnh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DIST_W-1:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink (input valid, hit, distance, output ready);
endinterface

>>> rtl/rtnh_mac.sv
// Bit-serial signed multiply-accumulate unit shared by every product of the engine.
module rtnh_mac import rtnh_pkg::*; #(
    parameter int AW = 240,
    parameter int BW = 68
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mac_ctl             i_ctl,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [AW-1:0] i_init,
    input  logic signed [BW-1:0] i_b,
    output logic                 o_busy,
    output logic signed [AW-1:0] o_acc
);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_sub;
    logic signed [AW-1:0] r_a;
    logic signed [AW-1:0] r_acc;
    logic signed [BW-1:0] r_b;

    logic                 last;
    logic                 neg;
    logic signed [AW-1:0] n_acc;

    // The top multiplier bit carries negative weight; a subtract flips every term.
    always_comb begin
        last  = (r_cnt == CNT_W'(1));
        neg   = last ^ r_sub;
        n_acc = r_acc;
        if (r_b[0]) begin
            n_acc = neg ? (r_acc - r_a) : (r_acc + r_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_ctl.nbits;
            r_sub  <= i_ctl.sub;
            r_a    <= i_a;
            r_b    <= i_b;
            case (i_ctl.mode)
                ACC_ZERO: r_acc <= '0;
                ACC_LOAD: r_acc <= i_init;
                default:  r_acc <= r_acc;
            endcase
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= r_a <<< 1;
            r_b   <= r_b >>> 1;
            r_cnt <= r_cnt - CNT_W'(1);
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;

endmodule

>>> rtl/rtnh_div.sv
// Restoring serial divider giving the saturated Q16.16 ray parameter.
module rtnh_div import rtnh_pkg::*; #(
    parameter int NUM_W = 102,
    parameter int DEN_W = 101
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_busy,
    output logic [DIST_W-1:0] o_quot
);

    localparam int DV = ((NUM_W + FRAC_BITS > DEN_W + DIST_W) ?
                         (NUM_W + FRAC_BITS) : (DEN_W + DIST_W)) + 1;
    localparam int QC_W = $clog2(DIST_W + 1);

    logic              r_busy;
    logic              r_first;
    logic [QC_W-1:0]   r_cnt;
    logic [DV-1:0]     r_rem;
    logic [DV-1:0]     r_dsh;
    logic [DIST_W-1:0] r_q;

    logic [DV-1:0] diff;
    logic          ge;

    always_comb begin
        diff = r_rem - r_dsh;
        ge   = !diff[DV-1];
    end

    // The first step only tests for a quotient of 2^32 or more, which saturates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_first <= 1'b1;
            r_cnt   <= QC_W'(DIST_W);
            r_rem   <= DV'({i_num, {FRAC_BITS{1'b0}}});
            r_dsh   <= DV'({i_den, {DIST_W{1'b0}}});
            r_q     <= '0;
        end else if (r_busy) begin
            if (r_first) begin
                r_first <= 1'b0;
                r_dsh   <= r_dsh >> 1;
                if (ge) begin
                    r_q    <= '1;
                    r_busy <= 1'b0;
                end
            end else begin
                if (ge) begin
                    r_rem <= diff;
                end
                r_q   <= {r_q[DIST_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - QC_W'(1);
                if (r_cnt == QC_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

>>> rtl/ray_triangle_nearest_hit.sv
// Ray and triangle nearest-hit engine: top level with sequencer, state and result register.
//
// Software first writes the ray origin and direction through the configuration port
// (index 0 to 2 origin x, y, z, index 3 to 5 direction x, y, z, signed Q16.16), while
// the engine is idle. Triangles then arrive as words on i_tri, three vertices each; the
// word carrying final_tri closes the ray. For that word alone one result word leaves on
// o_res: the hit flag and the nearest ray parameter as unsigned Q16.16, all ones when no
// triangle was hit. The best distance and hit flag then return to their reset values.
//
// One triangle word occupies the engine for its whole evaluation; i_tri.ready is high
// only while the engine is idle. Every product goes through one bit-serial
// multiply-accumulate unit, one multiplier bit per cycle, so the time per word grows with
// the operand widths of its products: a triangle that passes every test takes longest,
// one that an early test rejects takes less. The division runs on its own serial divider
// alongside the edge tests and adds no time. A rejected triangle ends at once.
//
// Reset clears the ray registers to zero, empties the result register and restores the
// best distance to all ones. When the receiver stalls, the result word waits in the
// output register; a closing triangle holds the engine until that register is free.
module ray_triangle_nearest_hit import rtnh_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    rtnh_tri_if.sink             i_tri,
    rtnh_res_if.source           o_res
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;          // vertex differences
    localparam int NW    = 2 * W + 3;      // normal components
    localparam int MB    = 2 * W + 4;      // widest multiplier operand
    localparam int DEN_W = 3 * W + 5;
    localparam int NUM_W = 3 * W + 6;
    localparam int QW    = 4 * W + 7;      // scaled plane point offsets
    localparam int XW    = 5 * W + 9;      // edge cross products
    localparam int AW    = 7 * W + 16;     // accumulator

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ISSUE,
        S_WAIT,
        S_TAIL,
        S_END
    } t_state;

    typedef enum logic [5:0] {
        OP_D0, OP_D1, OP_D2, OP_SQ, OP_SQK,
        OP_L0, OP_L1, OP_L2, OP_M0, OP_M1, OP_M2, OP_LM, OP_CMP,
        OP_NX0, OP_NX1, OP_NY0, OP_NY1, OP_NZ0, OP_NZ1,
        OP_DEN0, OP_DEN1, OP_DEN2, OP_NUM0, OP_NUM1, OP_NUM2,
        OP_QX0, OP_QX1, OP_QY0, OP_QY1, OP_QZ0, OP_QZ1,
        OP_CX0, OP_CX1, OP_CY0, OP_CY1, OP_CZ0, OP_CZ1,
        OP_E0, OP_E1, OP_E2
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [1:0] r_edge;

    logic signed [W-1:0] r_org [3];
    logic signed [W-1:0] r_dir [3];
    logic signed [W-1:0] r_v [3][3];
    logic                r_final;

    logic signed [MB-1:0]    r_dot;
    logic signed [AW-1:0]    r_t1;
    logic signed [AW-1:0]    r_t2;
    logic signed [NW-1:0]    r_n [3];
    logic signed [DEN_W-1:0] r_den;
    logic signed [NUM_W-1:0] r_num;
    logic signed [QW-1:0]    r_q [3];
    logic signed [XW-1:0]    r_c [3];

    logic [DIST_W-1:0] r_best;
    logic              r_found;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [DIST_W-1:0] r_out_dist;

    logic signed [DW-1:0] s [3][3];
    logic signed [DW-1:0] e [3];
    logic signed [DW-1:0] ov [3][3];
    logic signed [DW-1:0] w [3];
    logic signed [DW-1:0] se [3];
    logic signed [DW-1:0] ovs [3];
    logic                 zero_edge;

    t_mac_ctl             ctl;
    logic signed [AW-1:0] op_a;
    logic signed [MB-1:0] op_b;
    logic                 mac_busy;
    logic signed [AW-1:0] mac_acc;

    logic                 reject;
    logic                 div_start;
    logic                 div_busy;
    logic [DIST_W-1:0]    div_quot;
    logic [NUM_W-1:0]     num_lo;
    logic [NUM_W-1:0]     num_abs;
    logic [DEN_W-1:0]     den_abs;
    logic                 out_free;
    logic                 out_load;

    // Edge vectors, the origin offsets and the vectors of the edge under test.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s[0][k] = DW'(r_v[1][k]) - DW'(r_v[0][k]);
            s[1][k] = DW'(r_v[2][k]) - DW'(r_v[1][k]);
            s[2][k] = DW'(r_v[0][k]) - DW'(r_v[2][k]);
            e[k]    = DW'(r_v[2][k]) - DW'(r_v[0][k]);
            w[k]    = DW'(r_v[0][k]) - DW'(r_org[k]);
            for (int i = 0; i < 3; i++) begin
                ov[i][k] = DW'(r_org[k]) - DW'(r_v[i][k]);
            end
            se[k]  = s[r_edge][k];
            ovs[k] = ov[r_edge][k];
        end
        zero_edge = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (s[i][0] == '0 && s[i][1] == '0 && s[i][2] == '0) begin
                zero_edge = 1'b1;
            end
        end
    end

    // Operand selection for each step of the sequencer.
    always_comb begin
        ctl.start = (r_state == S_ISSUE);
        ctl.mode  = ACC_KEEP;
        ctl.sub   = 1'b0;
        ctl.nbits = CNT_W'(DW);
        op_a      = '0;
        op_b      = '0;
        case (r_op)
            // Near-parallel test: 10000 (s1.e)^2 - 9801 |s1|^2 |e|^2.
            OP_D0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(s[0][0]); op_b = MB'(e[0]);
            end
            OP_D1: begin op_a = AW'(s[0][1]); op_b = MB'(e[1]); end
            OP_D2: begin op_a = AW'(s[0][2]); op_b = MB'(e[2]); end
            OP_SQ: begin
                ctl.mode = ACC_ZERO; ctl.nbits = CNT_W'(MB);
                op_a = AW'(r_dot); op_b = r_dot;
            end
            OP_SQK: begin
                ctl.mode = ACC_ZERO; ctl.nbits = CNT_W'(KW);
                op_a = r_t1; op_b = MB'(COS_SQ_DEN);
            end
            OP_L0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(s[0][0]); op_b = MB'(s[0][0]);
            end
            OP_L1: begin op_a = AW'(s[0][1]); op_b = MB'(s[0][1]); end
            OP_L2: begin op_a = AW'(s[0][2]); op_b = MB'(s[0][2]); end
            OP_M0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(e[0]); op_b = MB'(e[0]);
            end
            OP_M1: begin op_a = AW'(e[1]); op_b = MB'(e[1]); end
            OP_M2: begin op_a = AW'(e[2]); op_b = MB'(e[2]); end
            OP_LM: begin
                ctl.mode = ACC_ZERO; ctl.nbits = CNT_W'(MB);
                op_a = r_t2; op_b = r_dot;
            end
            OP_CMP: begin
                ctl.mode = ACC_LOAD; ctl.sub = 1'b1; ctl.nbits = CNT_W'(KW);
                op_a = r_t2; op_b = MB'(COS_SQ_NUM);
            end
            // Normal n = s1 x e.
            OP_NX0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(s[0][1]); op_b = MB'(e[2]);
            end
            OP_NX1: begin ctl.sub = 1'b1; op_a = AW'(s[0][2]); op_b = MB'(e[1]); end
            OP_NY0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(s[0][2]); op_b = MB'(e[0]);
            end
            OP_NY1: begin ctl.sub = 1'b1; op_a = AW'(s[0][0]); op_b = MB'(e[2]); end
            OP_NZ0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(s[0][0]); op_b = MB'(e[1]);
            end
            OP_NZ1: begin ctl.sub = 1'b1; op_a = AW'(s[0][1]); op_b = MB'(e[0]); end
            // Denominator n.D and numerator n.(v0 - O).
            OP_DEN0: begin
                ctl.mode = ACC_ZERO; ctl.nbits = CNT_W'(W);
                op_a = AW'(r_n[0]); op_b = MB'(r_dir[0]);
            end
            OP_DEN1: begin
                ctl.nbits = CNT_W'(W);
                op_a = AW'(r_n[1]); op_b = MB'(r_dir[1]);
            end
            OP_DEN2: begin
                ctl.nbits = CNT_W'(W);
                op_a = AW'(r_n[2]); op_b = MB'(r_dir[2]);
            end
            OP_NUM0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(r_n[0]); op_b = MB'(w[0]);
            end
            OP_NUM1: begin op_a = AW'(r_n[1]); op_b = MB'(w[1]); end
            OP_NUM2: begin op_a = AW'(r_n[2]); op_b = MB'(w[2]); end
            // q = den (O - v_i) + num D for the edge under test.
            OP_QX0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(r_den); op_b = MB'(ovs[0]);
            end
            OP_QX1: begin
                ctl.nbits = CNT_W'(W);
                op_a = AW'(r_num); op_b = MB'(r_dir[0]);
            end
            OP_QY0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(r_den); op_b = MB'(ovs[1]);
            end
            OP_QY1: begin
                ctl.nbits = CNT_W'(W);
                op_a = AW'(r_num); op_b = MB'(r_dir[1]);
            end
            OP_QZ0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(r_den); op_b = MB'(ovs[2]);
            end
            OP_QZ1: begin
                ctl.nbits = CNT_W'(W);
                op_a = AW'(r_num); op_b = MB'(r_dir[2]);
            end
            // c = s_i x q.
            OP_CX0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(r_q[2]); op_b = MB'(se[1]);
            end
            OP_CX1: begin ctl.sub = 1'b1; op_a = AW'(r_q[1]); op_b = MB'(se[2]); end
            OP_CY0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(r_q[0]); op_b = MB'(se[2]);
            end
            OP_CY1: begin ctl.sub = 1'b1; op_a = AW'(r_q[2]); op_b = MB'(se[0]); end
            OP_CZ0: begin
                ctl.mode = ACC_ZERO;
                op_a = AW'(r_q[1]); op_b = MB'(se[0]);
            end
            OP_CZ1: begin ctl.sub = 1'b1; op_a = AW'(r_q[0]); op_b = MB'(se[1]); end
            // Edge value n.c.
            OP_E0: begin
                ctl.mode = ACC_ZERO; ctl.nbits = CNT_W'(NW);
                op_a = AW'(r_c[0]); op_b = MB'(r_n[0]);
            end
            OP_E1: begin
                ctl.nbits = CNT_W'(NW);
                op_a = AW'(r_c[1]); op_b = MB'(r_n[1]);
            end
            OP_E2: begin
                ctl.nbits = CNT_W'(NW);
                op_a = AW'(r_c[2]); op_b = MB'(r_n[2]);
            end
            default: ;
        endcase
    end

    // Tests applied when a step that closes a quantity completes.
    always_comb begin
        reject = 1'b0;
        case (r_op)
            OP_CMP:  reject = !mac_acc[AW-1] && (mac_acc != '0);
            OP_NUM2: reject = (r_den == '0) || (mac_acc == '0) ||
                              (mac_acc[AW-1] != r_den[DEN_W-1]);
            OP_E2:   reject = (mac_acc != '0) && (mac_acc[AW-1] != r_den[DEN_W-1]);
            default: reject = 1'b0;
        endcase
        num_lo    = mac_acc[NUM_W-1:0];
        num_abs   = mac_acc[AW-1] ? (~num_lo + NUM_W'(1)) : num_lo;
        den_abs   = r_den[DEN_W-1] ? (~r_den + DEN_W'(1)) : r_den;
        div_start = (r_state == S_WAIT) && !mac_busy && (r_op == OP_NUM2) && !reject;
        out_free  = !r_out_valid || o_res.ready;
        out_load  = (r_state == S_END) && r_final && out_free;
    end

    rtnh_mac #(
        .AW (AW),
        .BW (MB)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_a     (op_a),
        .i_init  (r_t1),
        .i_b     (op_b),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    rtnh_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_abs),
        .i_den   (den_abs),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_D0;
            r_edge      <= '0;
            r_best      <= '1;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= '0;
                r_dir[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_ORG_X: r_org[0] <= W'(i_cfg_data);
                    REG_ORG_Y: r_org[1] <= W'(i_cfg_data);
                    REG_ORG_Z: r_org[2] <= W'(i_cfg_data);
                    REG_DIR_X: r_dir[0] <= W'(i_cfg_data);
                    REG_DIR_Y: r_dir[1] <= W'(i_cfg_data);
                    REG_DIR_Z: r_dir[2] <= W'(i_cfg_data);
                    default: ;
                endcase
            end

            // A new result word may replace one that leaves in the same cycle.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_tri.valid) begin
                        r_v[0][0] <= i_tri.a_x;
                        r_v[0][1] <= i_tri.a_y;
                        r_v[0][2] <= i_tri.a_z;
                        r_v[1][0] <= i_tri.b_x;
                        r_v[1][1] <= i_tri.b_y;
                        r_v[1][2] <= i_tri.b_z;
                        r_v[2][0] <= i_tri.c_x;
                        r_v[2][1] <= i_tri.c_y;
                        r_v[2][2] <= i_tri.c_z;
                        r_final   <= i_tri.final_tri;
                        r_state   <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_op   <= OP_D0;
                    r_edge <= '0;
                    r_state <= zero_edge ? S_END : S_ISSUE;
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!mac_busy) begin
                        case (r_op)
                            OP_D2:   r_dot  <= mac_acc[MB-1:0];
                            OP_SQ:   r_t1   <= mac_acc;
                            OP_SQK:  r_t1   <= mac_acc;
                            OP_L2:   r_t2   <= mac_acc;
                            OP_M2:   r_dot  <= mac_acc[MB-1:0];
                            OP_LM:   r_t2   <= mac_acc;
                            OP_NX1:  r_n[0] <= mac_acc[NW-1:0];
                            OP_NY1:  r_n[1] <= mac_acc[NW-1:0];
                            OP_NZ1:  r_n[2] <= mac_acc[NW-1:0];
                            OP_DEN2: r_den  <= mac_acc[DEN_W-1:0];
                            OP_NUM2: r_num  <= mac_acc[NUM_W-1:0];
                            OP_QX1:  r_q[0] <= mac_acc[QW-1:0];
                            OP_QY1:  r_q[1] <= mac_acc[QW-1:0];
                            OP_QZ1:  r_q[2] <= mac_acc[QW-1:0];
                            OP_CX1:  r_c[0] <= mac_acc[XW-1:0];
                            OP_CY1:  r_c[1] <= mac_acc[XW-1:0];
                            OP_CZ1:  r_c[2] <= mac_acc[XW-1:0];
                            default: ;
                        endcase
                        if (reject) begin
                            r_state <= S_END;
                        end else if (r_op == OP_E2) begin
                            if (r_edge == 2'd2) begin
                                r_state <= S_TAIL;
                            end else begin
                                r_edge  <= r_edge + 2'd1;
                                r_op    <= OP_QX0;
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_op    <= t_op'(r_op + 6'd1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_TAIL: begin
                    // All edges passed; the hit counts only if it is nearer.
                    if (!div_busy) begin
                        if (div_quot < r_best) begin
                            r_best  <= div_quot;
                            r_found <= 1'b1;
                        end
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (!r_final) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_hit   <= r_found;
                        r_out_dist  <= r_best;
                        r_best      <= '1;
                        r_found     <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_tri.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.hit      = r_out_hit;
    assign o_res.distance = r_out_dist;

endmodule
